@@ hw/rtl/mps_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// mps_pkg
// Shared constants for the matrix palette skinning block.
// ---------------------------------------------------------------------------
package mps_pkg;

   localparam int JOINT_COUNT_DEF = 64;
   localparam int WORDS_PER_JOINT = 12;
   localparam int WORD_W          = 32;
   localparam int ROW_W           = WORDS_PER_JOINT * WORD_W;
   localparam int INFLUENCES      = 4;
   localparam int REQ_DATA_W      = 336;
   localparam int RSP_DATA_W      = 192;
   localparam int OUT_DEPTH       = 4;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_SKIN  = 1'b1;

endpackage
`default_nettype wire

@@ hw/rtl/matrix_palette_vertex_skinning.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// matrix_palette_vertex_skinning
// Four-influence linear blend skinning over a Q16.16 joint matrix palette.
// ---------------------------------------------------------------------------
// A skin item reads one joint row per influence in turn, since the palette
// memory gives one 12-word joint row per cycle on its single read port. A
// new item is accepted while the last influence of the one before is read,
// unless the skin items in flight fill the 4-entry output queue in which
// results wait. Palette contents are undefined until written.
module matrix_palette_vertex_skinning #(
   parameter int JOINT_COUNT = mps_pkg::JOINT_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // entry_index, element_index, entry_value, position_x/y/z,
   // normal_x/y/z, joint_indices, weight_set, zero pad
   input  wire logic [mps_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  wire logic                          req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // skinned_x/y/z, skinned_normal_x/y/z
   output logic [mps_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int IW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
   localparam int NW = mps_pkg::WORDS_PER_JOINT;
   localparam int CW = $clog2(mps_pkg::OUT_DEPTH + 1);
   localparam int PW = $clog2(mps_pkg::OUT_DEPTH);

   typedef logic signed [31:0] word_type;

   logic [mps_pkg::ROW_W-1:0] mem_ff [JOINT_COUNT];

   logic           acc_req, acc_rsp;
   logic [5:0]     wr_entry;
   logic [3:0]     wr_elem;
   logic [8:0]     wr_entry_x;

   logic           busy_ff;
   logic [1:0]     k_ff;
   logic [31:0]    it_joint_ff;
   logic [63:0]    it_w_ff;
   word_type       it_vec_ff [6];

   logic [7:0]     cur_joint;
   logic           cur_ok;
   logic [mps_pkg::ROW_W-1:0] rd_row_ff;
   logic [15:0]    rd_w_ff;
   logic           rd_ok_ff, rd_vld_ff, rd_first_ff, rd_last_ff;
   word_type       rd_vec_ff [6];

   logic signed [48:0] prod_ff [NW];
   logic           m_vld_ff, m_first_ff, m_last_ff;
   word_type       m_vec_ff [6];

   logic signed [50:0] acc_ff [NW];
   logic           acc_done_ff;
   word_type       a_vec_ff [6];

   word_type       skin_ff [NW];
   word_type       b_vec_ff [6];
   logic           b_act_ff;
   logic [1:0]     r_ff;

   logic signed [63:0] pp_ff [6];
   logic signed [31:0] off_ff;
   logic           p_vld_ff;
   logic [1:0]     p_r_ff;

   logic signed [65:0] sum_ff [2];
   logic           s_vld_ff;
   logic [1:0]     s_r_ff;

   word_type       res_ff [2][2];
   logic           push;
   logic [mps_pkg::RSP_DATA_W-1:0] push_data;

   logic [mps_pkg::RSP_DATA_W-1:0] fifo_ff [mps_pkg::OUT_DEPTH];
   logic [PW-1:0]  wp_ff, rp_ff;
   logic [CW-1:0]  fcnt_ff, fcnt_in;
   logic [CW-1:0]  infl_ff, infl_in;

   function automatic word_type sat_skin(input logic signed [50:0] a);
      logic signed [50:0] t;
      t = (a + 51'sd16384) >>> 15;
      if (t > 51'sd2147483647) return 32'sh7FFFFFFF;
      else if (t < -51'sd2147483648) return 32'sh80000000;
      else return t[31:0];
   endfunction

   function automatic word_type sat_out(input logic signed [65:0] a);
      logic signed [65:0] t;
      t = (a + 66'sd32768) >>> 16;
      if (t > 66'sd2147483647) return 32'sh7FFFFFFF;
      else if (t < -66'sd2147483648) return 32'sh80000000;
      else return t[31:0];
   endfunction

   assign req_tready = (!busy_ff || k_ff == 2'd3) && (infl_ff < CW'(mps_pkg::OUT_DEPTH));
   assign acc_req    = req_tvalid && req_tready;
   assign acc_rsp    = rsp_tvalid && rsp_tready;
   assign wr_entry   = req_tdata[5:0];
   assign wr_elem    = req_tdata[9:6];
   assign wr_entry_x = {3'b000, wr_entry};

   assign cur_joint  = it_joint_ff[8*k_ff +: 8];
   assign cur_ok     = {1'b0, cur_joint} < 9'(JOINT_COUNT);

   // palette memory
   always_ff @(posedge clock) begin
      if (acc_req && req_tuser == mps_pkg::ACT_WRITE && wr_entry_x < 9'(JOINT_COUNT)
          && wr_elem < 4'(NW)) begin
         mem_ff[wr_entry_x[IW-1:0]][32*wr_elem +: 32] <= req_tdata[41:10];
      end
      rd_row_ff <= mem_ff[cur_joint[IW-1:0]];
   end

   // influence sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= 2'd0;
      end else if (acc_req && req_tuser == mps_pkg::ACT_SKIN) begin
         busy_ff <= 1'b1;
         k_ff    <= 2'd0;
      end else if (busy_ff) begin
         k_ff <= k_ff + 2'd1;
         if (k_ff == 2'd3) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc_req && req_tuser == mps_pkg::ACT_SKIN) begin
         it_joint_ff <= req_tdata[265:234];
         it_w_ff     <= req_tdata[329:266];
         for (int i = 0; i < 6; i++) it_vec_ff[i] <= req_tdata[42+32*i +: 32];
      end
      rd_w_ff     <= it_w_ff[16*k_ff +: 16];
      rd_ok_ff    <= cur_ok;
      rd_first_ff <= k_ff == 2'd0;
      rd_last_ff  <= k_ff == 2'd3;
      rd_vec_ff   <= it_vec_ff;
      m_vec_ff    <= rd_vec_ff;
      m_first_ff  <= rd_first_ff;
      m_last_ff   <= rd_last_ff;
      for (int e = 0; e < NW; e++) begin
         prod_ff[e] <= rd_ok_ff ?
            $signed({1'b0, rd_w_ff}) * $signed(rd_row_ff[32*e +: 32]) : 49'sd0;
      end
      if (m_vld_ff) begin
         for (int e = 0; e < NW; e++)
            acc_ff[e] <= (m_first_ff ? 51'sd0 : acc_ff[e]) + 51'(prod_ff[e]);
         if (m_last_ff) a_vec_ff <= m_vec_ff;
      end
   end

   // blend and transform control
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff   <= 1'b0;
         m_vld_ff    <= 1'b0;
         acc_done_ff <= 1'b0;
         b_act_ff    <= 1'b0;
         r_ff        <= 2'd0;
         p_vld_ff    <= 1'b0;
         s_vld_ff    <= 1'b0;
      end else begin
         rd_vld_ff   <= busy_ff;
         m_vld_ff    <= rd_vld_ff;
         acc_done_ff <= m_vld_ff && m_last_ff;
         p_vld_ff    <= b_act_ff;
         s_vld_ff    <= p_vld_ff;
         if (acc_done_ff) begin
            b_act_ff <= 1'b1;
            r_ff     <= 2'd0;
         end else if (b_act_ff) begin
            if (r_ff == 2'd2) b_act_ff <= 1'b0;
            else r_ff <= r_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc_done_ff) begin
         for (int e = 0; e < NW; e++) skin_ff[e] <= sat_skin(acc_ff[e]);
         b_vec_ff <= a_vec_ff;
      end
      for (int c = 0; c < 3; c++) begin
         pp_ff[c]   <= skin_ff[4*r_ff + c] * b_vec_ff[c];
         pp_ff[3+c] <= skin_ff[4*r_ff + c] * b_vec_ff[3+c];
      end
      off_ff <= skin_ff[4*r_ff + 3];
      p_r_ff <= r_ff;
      sum_ff[0] <= 66'(pp_ff[0]) + 66'(pp_ff[1]) + 66'(pp_ff[2]) + (66'(off_ff) <<< 16);
      sum_ff[1] <= 66'(pp_ff[3]) + 66'(pp_ff[4]) + 66'(pp_ff[5]);
      s_r_ff <= p_r_ff;
      if (s_vld_ff && s_r_ff != 2'd2) begin
         res_ff[s_r_ff[0]][0] <= sat_out(sum_ff[0]);
         res_ff[s_r_ff[0]][1] <= sat_out(sum_ff[1]);
      end
   end

   assign push      = s_vld_ff && s_r_ff == 2'd2;
   assign push_data = {sat_out(sum_ff[1]), res_ff[1][1], res_ff[0][1],
                       sat_out(sum_ff[0]), res_ff[1][0], res_ff[0][0]};

   always_comb begin
      fcnt_in = fcnt_ff + CW'(push) - CW'(acc_rsp);
      infl_in = infl_ff + CW'(acc_req && req_tuser == mps_pkg::ACT_SKIN) - CW'(acc_rsp);
   end

   // output queue
   always_ff @(posedge clock) begin
      if (push) fifo_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         fcnt_ff <= '0;
         infl_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + PW'(1);
         if (acc_rsp) rp_ff <= rp_ff + PW'(1);
         fcnt_ff <= fcnt_in;
         infl_ff <= infl_in;
      end
   end

   assign rsp_tvalid = fcnt_ff != '0;
   assign rsp_tdata  = fifo_ff[rp_ff];

   a_infl_bound: assert property (@(posedge clock) disable iff (reset)
      infl_ff <= CW'(mps_pkg::OUT_DEPTH))
      else $error("in-flight count over queue depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (fcnt_ff < CW'(mps_pkg::OUT_DEPTH) || acc_rsp))
      else $error("output queue overflow");
   a_queue_le_infl: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= infl_ff)
      else $error("queued results exceed accepted items");
   a_b_spacing: assert property (@(posedge clock) disable iff (reset)
      acc_done_ff |-> !b_act_ff || r_ff == 2'd2)
      else $error("transform stage overrun");

endmodule
`default_nettype wire
